### rtl/tmdd_pkg.sv
package tmdd_pkg;

    // Default sizing of the top level
    localparam int MAX_COLS_DEF  = 256;
    localparam int MAX_ROWS_DEF  = 1024;
    localparam int CELL_BITS_DEF = 24;

    // Register file layout
    localparam int ROWS_CFG_W = 11;
    localparam int COLS_CFG_W = 9;
    localparam int COEF_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Q0.16 coefficients
    localparam int FRAC_BITS = 16;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET   = 11'd64;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET   = 9'd64;
    localparam logic [COEF_W-1:0]     WEIGHT_RESET = 16'd6554;
    localparam logic [COEF_W-1:0]     DECAY_RESET  = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_ROWS     = 2'd0,
        REG_GRID_COLS     = 2'd1,
        REG_SPREAD_WEIGHT = 2'd2,
        REG_DECAY_FACTOR  = 2'd3
    } cfg_reg_t;

    // Sequencer -> datapath
    typedef struct packed {
        logic take;
        logic update;
        logic sum;
        logic mul1;
        logic mul2;
        logic emit;
    } tmdd_cmd_t;

    // Datapath -> sequencer
    typedef struct packed {
        logic drop;
        logic centre_valid;
        logic out_free;
    } tmdd_stat_t;

endpackage

### rtl/tmdd_if.sv
interface tmdd_in_if #(
    parameter int CELL_BITS = tmdd_pkg::CELL_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [CELL_BITS-1:0] cell_value;
    logic                        is_padding;

    modport source (output valid, output cell_value, output is_padding, input ready);
    modport sink   (input valid, input cell_value, input is_padding, output ready);
endinterface

interface tmdd_out_if #(
    parameter int CELL_BITS = tmdd_pkg::CELL_BITS_DEF,
    parameter int ROW_W     = $clog2(tmdd_pkg::MAX_ROWS_DEF),
    parameter int COL_W     = $clog2(tmdd_pkg::MAX_COLS_DEF)
);
    logic                        valid;
    logic                        ready;
    logic signed [CELL_BITS-1:0] new_value;
    logic [ROW_W-1:0]            out_row;
    logic [COL_W-1:0]            out_col;
    logic                        frame_last;

    modport source (output valid, output new_value, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input new_value, input out_row, input out_col,
                    input frame_last, output ready);
endinterface

### rtl/tmdd_ram.sv
module tmdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### rtl/tmdd_ctrl.sv
module tmdd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tmdd_pkg::tmdd_stat_t stat,
    output logic                in_ready,
    output tmdd_pkg::tmdd_cmd_t  cmd
);
    import tmdd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_UPDATE = 6'b000010,
        ST_SUM    = 6'b000100,
        ST_MUL1   = 6'b001000,
        ST_MUL2   = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    // dropped padding stays idle; line-store contents and counters are left as they were
                    if (!stat.drop)
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = stat.centre_valid ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

### rtl/tmdd_datapath.sv
module tmdd_datapath #(
    parameter int MAX_COLS  = tmdd_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = tmdd_pkg::MAX_ROWS_DEF,
    parameter int CELL_BITS = tmdd_pkg::CELL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tmdd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmdd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  tmdd_pkg::tmdd_cmd_t                 cmd,
    output tmdd_pkg::tmdd_stat_t                stat,
    input  logic signed [CELL_BITS-1:0]         cell_value,
    input  logic                                is_padding,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [CELL_BITS-1:0]         new_value,
    output logic [$clog2(MAX_ROWS)-1:0]         out_row,
    output logic [$clog2(MAX_COLS)-1:0]         out_col,
    output logic                                frame_last
);
    import tmdd_pkg::*;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COLS_W  = $clog2(MAX_COLS + 1);
    localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
    localparam int PEND_W  = $clog2(MAX_COLS + 2);
    localparam int SUM_W   = CELL_BITS + 4;
    localparam int PROD_W  = SUM_W + COEF_W + 1;
    localparam int RC_W    = (ROWS_W > ROWS_CFG_W) ? ROWS_W : ROWS_CFG_W;
    localparam int CC_W    = (COLS_W > COLS_CFG_W) ? COLS_W : COLS_CFG_W;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (CELL_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    // ---------------- configuration ----------------
    logic [ROWS_CFG_W-1:0] grid_rows_reg;
    logic [COLS_CFG_W-1:0] grid_cols_reg;
    logic [COEF_W-1:0]     spread_weight_reg;
    logic [COEF_W-1:0]     decay_factor_reg;
    logic                  size_clear;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg     <= ROWS_RESET;
            grid_cols_reg     <= COLS_RESET;
            spread_weight_reg <= WEIGHT_RESET;
            decay_factor_reg  <= DECAY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_ROWS:     grid_rows_reg     <= cfg_data[ROWS_CFG_W-1:0];
                REG_GRID_COLS:     grid_cols_reg     <= cfg_data[COLS_CFG_W-1:0];
                REG_SPREAD_WEIGHT: spread_weight_reg <= cfg_data[COEF_W-1:0];
                REG_DECAY_FACTOR:  decay_factor_reg  <= cfg_data[COEF_W-1:0];
                default:           ;
            endcase
        end
    end

    assign size_clear = cfg_we && (cfg_index == REG_GRID_ROWS || cfg_index == REG_GRID_COLS);

    // effective sizes, clamped to [1, MAX]
    logic [RC_W-1:0]   rows_cfg_ext;
    logic [CC_W-1:0]   cols_cfg_ext;
    logic [ROWS_W-1:0] eff_rows;
    logic [COLS_W-1:0] eff_cols;

    assign rows_cfg_ext = RC_W'(grid_rows_reg);
    assign cols_cfg_ext = CC_W'(grid_cols_reg);

    always_comb
    begin
        if (rows_cfg_ext == '0)
            eff_rows = ROWS_W'(1);
        else if (rows_cfg_ext > RC_W'(MAX_ROWS))
            eff_rows = ROWS_W'(MAX_ROWS);
        else
            eff_rows = ROWS_W'(rows_cfg_ext);

        if (cols_cfg_ext == '0)
            eff_cols = COLS_W'(1);
        else if (cols_cfg_ext > CC_W'(MAX_COLS))
            eff_cols = COLS_W'(MAX_COLS);
        else
            eff_cols = COLS_W'(cols_cfg_ext);
    end

    // ---------------- input capture ----------------
    logic signed [CELL_BITS-1:0] x_reg;
    logic                        pad_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            x_reg   <= is_padding ? '0 : cell_value;
            pad_reg <= is_padding;
        end
    end

    // ---------------- line stores ----------------
    logic [COL_W-1:0]            line_ptr_reg;
    logic                        filled_reg;   // line pointer has wrapped since clear
    logic [CELL_BITS-1:0]        upper_rd;
    logic [CELL_BITS:0]          middle_rd;
    logic signed [CELL_BITS-1:0] a_cell;
    logic signed [CELL_BITS-1:0] b_cell;
    logic                        b_valid;
    logic                        ptr_wrap;

    tmdd_ram #(.WIDTH(CELL_BITS), .DEPTH(MAX_COLS)) u_upper_ram (
        .clk     (clk),
        .wr_en   (cmd.update),
        .wr_addr (line_ptr_reg),
        .wr_data (b_cell),
        .rd_en   (cmd.take),
        .rd_addr (line_ptr_reg),
        .rd_data (upper_rd)
    );

    tmdd_ram #(.WIDTH(CELL_BITS + 1), .DEPTH(MAX_COLS)) u_middle_ram (
        .clk     (clk),
        .wr_en   (cmd.update),
        .wr_addr (line_ptr_reg),
        .wr_data ({!pad_reg, x_reg}),
        .rd_en   (cmd.take),
        .rd_addr (line_ptr_reg),
        .rd_data (middle_rd)
    );

    // entries not yet written since the last clear read as zero / not valid
    assign a_cell   = filled_reg ? $signed(upper_rd) : '0;
    assign b_cell   = filled_reg ? $signed(middle_rd[CELL_BITS-1:0]) : '0;
    assign b_valid  = filled_reg && middle_rd[CELL_BITS];
    assign ptr_wrap = (COLS_W'(line_ptr_reg) + COLS_W'(1)) >= eff_cols;

    // ---------------- stream state ----------------
    logic signed [CELL_BITS-1:0] win_reg [9];
    logic                        lag_valid_reg;
    logic [ROW_W-1:0]            in_row_reg;
    logic [COL_W-1:0]            in_col_reg;
    logic [ROW_W-1:0]            out_row_reg;
    logic [COL_W-1:0]            out_col_reg;
    logic [PEND_W-1:0]           pending_reg;
    logic                        in_col_wrap;
    logic                        out_col_wrap;

    assign in_col_wrap  = (COLS_W'(in_col_reg) + COLS_W'(1)) >= eff_cols;
    assign out_col_wrap = (COLS_W'(out_col_reg) + COLS_W'(1)) >= eff_cols;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            lag_valid_reg <= 1'b0;
            filled_reg    <= 1'b0;
            line_ptr_reg  <= '0;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            pending_reg   <= '0;
        end
        else if (size_clear)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            lag_valid_reg <= 1'b0;
            filled_reg    <= 1'b0;
            line_ptr_reg  <= '0;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            pending_reg   <= '0;
        end
        else if (cmd.update)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]     <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[2]    <= a_cell;
            win_reg[5]    <= b_cell;
            win_reg[8]    <= x_reg;
            lag_valid_reg <= b_valid;

            if (ptr_wrap)
            begin
                line_ptr_reg <= '0;
                filled_reg   <= 1'b1;
            end
            else
            begin
                line_ptr_reg <= line_ptr_reg + COL_W'(1);
            end

            if (!pad_reg)
            begin
                pending_reg <= pending_reg + PEND_W'(1);
                if (in_col_wrap)
                begin
                    in_col_reg <= '0;
                    if ((ROWS_W'(in_row_reg) + ROWS_W'(1)) >= eff_rows)
                        in_row_reg <= '0;
                    else
                        in_row_reg <= in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
        end
        else if (cmd.sum)
        begin
            if (pending_reg != '0)
                pending_reg <= pending_reg - PEND_W'(1);
            if (out_col_wrap)
            begin
                out_col_reg <= '0;
                if ((ROWS_W'(out_row_reg) + ROWS_W'(1)) >= eff_rows)
                    out_row_reg <= '0;
                else
                    out_row_reg <= out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_reg <= out_col_reg + COL_W'(1);
            end
        end
    end

    // ---------------- neighborhood sum ----------------
    logic [2:0]              row_ok;
    logic [2:0]              col_ok;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic [ROW_W-1:0]        res_row_reg;
    logic [COL_W-1:0]        res_col_reg;
    logic                    res_last_reg;

    assign row_ok[0] = (out_row_reg != '0);
    assign row_ok[1] = 1'b1;
    assign row_ok[2] = (ROWS_W'(out_row_reg) + ROWS_W'(1)) < eff_rows;
    assign col_ok[0] = (out_col_reg != '0);
    assign col_ok[1] = 1'b1;
    assign col_ok[2] = !out_col_wrap;

    always_comb
    begin
        // centre counts twice
        sum_next = SUM_W'(win_reg[4]);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                if (row_ok[r] && col_ok[c])
                    sum_next = sum_next + SUM_W'(win_reg[r*3 + c]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            sum_reg      <= sum_next;
            res_row_reg  <= out_row_reg;
            res_col_reg  <= out_col_reg;
            res_last_reg <= (ROWS_W'(out_row_reg) == eff_rows - ROWS_W'(1)) && out_col_wrap;
        end
    end

    // ---------------- weight and decay ----------------
    logic signed [PROD_W-1:0]    prod1;
    logic signed [PROD_W-1:0]    prod2;
    logic signed [SUM_W-1:0]     acc_reg;
    logic signed [SUM_W-1:0]     res_full;
    logic signed [CELL_BITS-1:0] sat_reg;

    // arithmetic shift of the product = floor toward minus infinity
    assign prod1    = PROD_W'(sum_reg) * PROD_W'($signed({1'b0, spread_weight_reg}));
    assign prod2    = PROD_W'(acc_reg) * PROD_W'($signed({1'b0, decay_factor_reg}));
    assign res_full = prod2[FRAC_BITS +: SUM_W];

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            acc_reg <= prod1[FRAC_BITS +: SUM_W];
        end
        if (cmd.mul2)
        begin
            if (res_full > SAT_HI)
                sat_reg <= CELL_BITS'(SAT_HI);
            else if (res_full < SAT_LO)
                sat_reg <= CELL_BITS'(SAT_LO);
            else
                sat_reg <= CELL_BITS'(res_full);
        end
    end

    // ---------------- output register ----------------
    logic                        out_valid_reg;
    logic signed [CELL_BITS-1:0] new_value_reg;
    logic [ROW_W-1:0]            out_row_q_reg;
    logic [COL_W-1:0]            out_col_q_reg;
    logic                        frame_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            new_value_reg  <= sat_reg;
            out_row_q_reg  <= res_row_reg;
            out_col_q_reg  <= res_col_reg;
            frame_last_reg <= res_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_value  = new_value_reg;
    assign out_row    = out_row_q_reg;
    assign out_col    = out_col_q_reg;
    assign frame_last = frame_last_reg;

    // ---------------- status ----------------
    assign stat.drop         = is_padding &&
                               (in_row_reg != '0 || in_col_reg != '0 || pending_reg == '0);
    assign stat.centre_valid = lag_valid_reg;
    assign stat.out_free     = !out_valid_reg || out_ready;
endmodule

### rtl/trail_map_diffuse_decay_core.sv
// Trail map diffuse and decay. Cells of a rows x cols map arrive in raster order (column
// fastest) as signed Q16.8 beats on cell_in; each emitted beat on cell_out carries
// decay_factor * spread_weight * (sum of the in-grid 3x3 neighbors + the center once more),
// floored after each Q0.16 multiply and saturated to the cell width, together with its row,
// column and a frame_last flag on the last cell. Cells outside the grid count as zero. A cell
// comes out cols+1 input beats after it went in, so a frame is flushed with cols+1 padding
// beats (is_padding=1) or by the next frame; padding inside a frame or with nothing pending
// is taken and ignored. A beat that produces a cell goes through accept, line-store update,
// neighborhood sum, weight multiply, decay multiply and output load; one that produces none
// only the first two; ignored padding leaves ready high. The output load waits while the
// previous cell is still held in the output register. A single sequencer walks each beat
// through the line-store read port and the two multiply stages, so no new beat is taken
// until the last is through. Writing grid_rows or grid_cols restarts the stream immediately;
// no clearing pass runs, since a fill flag masks line-store entries not yet written.
// Configuration must be written only while the block is idle; the block does not enforce it.
module trail_map_diffuse_decay_core #(
    parameter int MAX_COLS  = tmdd_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = tmdd_pkg::MAX_ROWS_DEF,
    parameter int CELL_BITS = tmdd_pkg::CELL_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // register write port
    input  logic                            cfg_we,
    input  logic [tmdd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmdd_pkg::CFG_DATA_W-1:0] cfg_data,
    // streams
    tmdd_in_if.sink                         cell_in,
    tmdd_out_if.source                      cell_out
);
    import tmdd_pkg::*;

    tmdd_cmd_t  cmd;
    tmdd_stat_t stat;
    logic       in_ready;

    // sequencer: one beat at a time through update / sum / multiply / emit
    tmdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cell_in.valid),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // line stores, 3x3 window, counters, arithmetic and output register
    tmdd_datapath #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .CELL_BITS (CELL_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .cell_value (cell_in.cell_value),
        .is_padding (cell_in.is_padding),
        .out_ready  (cell_out.ready),
        .out_valid  (cell_out.valid),
        .new_value  (cell_out.new_value),
        .out_row    (cell_out.out_row),
        .out_col    (cell_out.out_col),
        .frame_last (cell_out.frame_last)
    );

    assign cell_in.ready = in_ready;
endmodule

### rtl/tmdd_checker.sv
module tmdd_checker #(
    parameter int CELL_BITS = tmdd_pkg::CELL_BITS_DEF,
    parameter int ROW_W     = $clog2(tmdd_pkg::MAX_ROWS_DEF),
    parameter int COL_W     = $clog2(tmdd_pkg::MAX_COLS_DEF)
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 in_pad,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [CELL_BITS-1:0] new_value,
    input logic [ROW_W-1:0]     out_row,
    input logic [COL_W-1:0]     out_col,
    input logic                 frame_last
);
    logic last_final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_final_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            last_final_reg <= frame_last;
        end
    end

    // held result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_value) &&
        $stable(out_row) && $stable(out_col) && $stable(frame_last))
        else $error("result beat changed while stalled");

    // a real cell keeps the sequencer busy for at least the next cycle
    a_busy_after_cell: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_pad |=> !in_ready)
        else $error("ready stayed high after a cell was taken");

    // the cell after a frame's last one starts the next frame at the origin
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_final_reg |-> out_row == '0 && out_col == '0)
        else $error("frame did not restart at row 0, column 0");
endmodule

bind trail_map_diffuse_decay_core tmdd_checker #(
    .CELL_BITS (CELL_BITS),
    .ROW_W     ($clog2(MAX_ROWS)),
    .COL_W     ($clog2(MAX_COLS))
) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cell_in.valid),
    .in_ready   (cell_in.ready),
    .in_pad     (cell_in.is_padding),
    .out_valid  (cell_out.valid),
    .out_ready  (cell_out.ready),
    .new_value  (cell_out.new_value),
    .out_row    (cell_out.out_row),
    .out_col    (cell_out.out_col),
    .frame_last (cell_out.frame_last)
);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import tmdd_pkg::*;

    localparam int CELL_W = CELL_BITS_DEF;
    localparam int ROW_W  = $clog2(MAX_ROWS_DEF);
    localparam int COL_W  = $clog2(MAX_COLS_DEF);

    localparam logic signed [CELL_W-1:0] CELL_MAX = {1'b0, {(CELL_W-1){1'b1}}};
    localparam logic signed [CELL_W-1:0] CELL_MIN = {1'b1, {(CELL_W-1){1'b0}}};

    // Random part length, counted in beats the block acts on
    localparam int unsigned RANDOM_BEATS = 1300;
    // Quiet cycles after the last expected cell before the block counts as idle
    localparam int unsigned SETTLE_CYCLES = 16;
    // Receiver hold-off used to back the block up into its input
    localparam int unsigned HOLD_CYCLES = 400;
    // Watchdog: cycles without any beat on either side
    localparam int unsigned QUIET_LIMIT = 5000;

    // One emitted cell as seen on cell_out
    typedef struct packed {
        logic signed [CELL_W-1:0] value;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic                     last;
    } cell_result_t;

    // Directed stimulus row: either a register write or one input beat, with an
    // optional hand-typed expected cell for the padding beat that emits it
    typedef struct packed {
        logic                  is_write;
        cfg_reg_t              reg_sel;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CELL_W-1:0]     cell_data;
        logic                  pad;
        logic                  typed;
        cell_result_t          want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tmdd_in_if  in_bus ();
    tmdd_out_if out_bus ();

    trail_map_diffuse_decay_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_in   (in_bus),
        .cell_out  (out_bus)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Blur/decay predictor state: its own copy of the registers, the two
    // line stores with the middle one's fill flags, the 3x3 window and the counters
    // ------------------------------------------------------------------
    logic [ROWS_CFG_W-1:0]    rows_cfg;
    logic [COLS_CFG_W-1:0]    cols_cfg;
    logic [COEF_W-1:0]        weight_cfg;
    logic [COEF_W-1:0]        decay_cfg;

    logic signed [CELL_W-1:0] upper_line [MAX_COLS_DEF];
    logic signed [CELL_W-1:0] middle_line [MAX_COLS_DEF];
    bit                       middle_full [MAX_COLS_DEF];
    logic signed [CELL_W-1:0] win [9];
    bit                       lag_full;
    int unsigned              in_row, in_col, out_row, out_col, pending, line_pos;

    // beats the block acted on (ignored padding excluded)
    int unsigned              beats_used;

    cell_result_t             expected_cells [$];
    int unsigned              mismatches;

    int unsigned              src_idle_pct;
    int unsigned              snk_idle_pct;
    int unsigned              holds_asked;
    int unsigned              holds_served;
    int unsigned              quiet_cycles;

    dir_row_t                 directed_rows [$];
    cell_result_t             want_cell;
    cell_result_t             seen_cell;

    // Out-of-range sizes clamp to 1 and to the line store depth / row limit
    function automatic int unsigned rows_eff();
        if (rows_cfg == 0) return 1;
        if (rows_cfg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
        return 32'(rows_cfg);
    endfunction

    function automatic int unsigned cols_eff();
        if (cols_cfg == 0) return 1;
        if (cols_cfg > MAX_COLS_DEF) return MAX_COLS_DEF;
        return 32'(cols_cfg);
    endfunction

    function automatic void restart_stream();
        for (int i = 0; i < MAX_COLS_DEF; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
            middle_full[i] = 1'b0;
        end
        for (int i = 0; i < 9; i++)
            win[i] = '0;
        lag_full = 1'b0;
        in_row   = 0;
        in_col   = 0;
        out_row  = 0;
        out_col  = 0;
        pending  = 0;
        line_pos = 0;
    endfunction

    // Size writes drop everything in flight; coefficient writes only apply to
    // cells emitted afterwards
    function automatic void note_reg_write(cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
        case (sel)
            REG_GRID_ROWS:
            begin
                rows_cfg = data[ROWS_CFG_W-1:0];
                restart_stream();
            end
            REG_GRID_COLS:
            begin
                cols_cfg = data[COLS_CFG_W-1:0];
                restart_stream();
            end
            REG_SPREAD_WEIGHT: weight_cfg = data[COEF_W-1:0];
            REG_DECAY_FACTOR:  decay_cfg  = data[COEF_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the stencil by one accepted beat; returns 1 with the emitted cell
    // when the beat pushes a real cell through the center of the window
    function automatic bit diffuse_cell(input logic signed [CELL_W-1:0] cell_data,
                                        input logic pad,
                                        output cell_result_t res);
        int unsigned              rows, cols, p;
        logic signed [CELL_W-1:0] x, a, b;
        bit                       vb, centre_ok;
        longint                   sum, acc, prod;
        int                       nr, nc;

        rows = rows_eff();
        cols = cols_eff();
        res  = '0;
        // padding mid-frame, or with nothing left to flush, is dropped
        if (pad && (in_row != 0 || in_col != 0)) return 1'b0;
        if (pad && pending == 0) return 1'b0;
        beats_used++;
        x = pad ? '0 : cell_data;

        p = line_pos;
        if (p >= cols) p = 0;
        a  = upper_line[p];
        b  = middle_line[p];
        vb = middle_full[p];
        upper_line[p]  = b;
        middle_line[p] = x;
        middle_full[p] = !pad;
        line_pos = (p + 1 >= cols) ? 0 : p + 1;

        for (int r = 0; r < 3; r++)
        begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = a;
        win[5] = b;
        win[8] = x;
        centre_ok = lag_full;
        lag_full  = vb;

        if (!pad)
        begin
            pending++;
            in_col++;
            if (in_col >= cols)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= rows) in_row = 0;
            end
        end
        if (!centre_ok) return 1'b0;

        // center counts twice; neighbors off the grid count as zero
        sum = longint'(win[4]);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                nr = int'(out_row) + r - 1;
                nc = int'(out_col) + c - 1;
                if (nr >= 0 && nr < int'(rows) && nc >= 0 && nc < int'(cols))
                    sum += longint'(win[r*3+c]);
            end
        end
        // two Q0.16 multiplies, each floored toward minus infinity
        acc  = (sum * longint'(weight_cfg)) >>> FRAC_BITS;
        prod = (acc * longint'(decay_cfg)) >>> FRAC_BITS;
        if (prod > longint'(CELL_MAX)) prod = longint'(CELL_MAX);
        if (prod < longint'(CELL_MIN)) prod = longint'(CELL_MIN);

        res.value = prod[CELL_W-1:0];
        res.row   = out_row[ROW_W-1:0];
        res.col   = out_col[COL_W-1:0];
        res.last  = (out_row == rows - 1) && (out_col == cols - 1);

        out_col++;
        if (out_col >= cols)
        begin
            out_col = 0;
            out_row++;
            if (out_row >= rows) out_row = 0;
        end
        if (pending > 0) pending--;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic dir_row_t reg_row(cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
        dir_row_t row;
        row          = '0;
        row.is_write = 1'b1;
        row.reg_sel  = sel;
        row.wdata    = data;
        return row;
    endfunction

    function automatic dir_row_t beat_row(logic [CELL_W-1:0] cell_data, logic pad);
        dir_row_t row;
        row           = '0;
        row.cell_data = cell_data;
        row.pad       = pad;
        return row;
    endfunction

    // Flush beat on a 1x1 grid: the emitted cell is always (0,0) and last
    function automatic dir_row_t checked_row(logic [CELL_W-1:0] value);
        dir_row_t row;
        row            = '0;
        row.cell_data  = 24'h3C3C3C;
        row.pad        = 1'b1;
        row.typed      = 1'b1;
        row.want.value = value;
        row.want.last  = 1'b1;
        return row;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [CELL_W-1:0] pick_cell();
        case ($urandom_range(7))
            0:       return CELL_MAX;
            1:       return CELL_MIN;
            2:       return CELL_W'($urandom_range(2047)) - CELL_W'(1024);
            default: return CELL_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything changes at the falling edge; each task is entered
    // and left right after a falling edge.
    // ------------------------------------------------------------------

    // One register write; the block is idle whenever this is called
    task automatic cfg_write(cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        note_reg_write(sel, data);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one beat after a random gap; at acceptance run the predictor and
    // queue what the block should emit for it
    task automatic send_beat(input logic [CELL_W-1:0] cell_data, input logic pad,
                             input bit typed, input cell_result_t want);
        cell_result_t got_cell;
        bit           has_cell;

        while ($urandom_range(99) < src_idle_pct)
        begin
            in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.cell_value <= cell_data;
        in_bus.is_padding <= pad;
        @(posedge clk);
        while (in_bus.ready !== 1'b1)
            @(posedge clk);
        has_cell = diffuse_cell(cell_data, pad, got_cell);
        if (typed)
            expected_cells = {expected_cells, want};
        else if (has_cell)
            expected_cells = {expected_cells, got_cell};
        @(negedge clk);
    endtask

    // Stop offering, wait for every queued cell, then let the pipe go quiet
    task automatic drain();
        in_bus.valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One grid setting with frames of random content. Small grids get whole
    // frames (back to back or flushed); big ones only a partial frame, which
    // the next size write throws away. The wide phase runs a 256-column grid
    // and stalls the receiver once results start to flow.
    task automatic run_phase(bit wide);
        logic [CFG_DATA_W-1:0] rows_w, cols_w;
        int unsigned           area, cells, frames, how;

        drain();
        if (wide)
        begin
            rows_w = 16'd1024;
            cols_w = $urandom_range(1) ? 16'hFFFF : 16'd256;
        end
        else
        begin
            case ($urandom_range(9))
                0:       rows_w = 16'd0;
                1:       rows_w = 16'd1;
                2:       rows_w = 16'h07FF;
                3:       rows_w = 16'(1024 + $urandom_range(1023));
                default: rows_w = 16'($urandom_range(2, 6));
            endcase
            case ($urandom_range(9))
                0:       cols_w = 16'd0;
                1:       cols_w = 16'd1;
                2:       cols_w = 16'd2;
                3:       cols_w = 16'($urandom_range(256, 511));
                default: cols_w = 16'($urandom_range(3, 9));
            endcase
            // bits above the register width are don't-care
            rows_w[CFG_DATA_W-1:ROWS_CFG_W] = (CFG_DATA_W-ROWS_CFG_W)'($urandom);
            cols_w[CFG_DATA_W-1:COLS_CFG_W] = (CFG_DATA_W-COLS_CFG_W)'($urandom);
        end
        if ($urandom_range(1))
        begin
            cfg_write(REG_GRID_ROWS, rows_w);
            cfg_write(REG_GRID_COLS, cols_w);
        end
        else
        begin
            cfg_write(REG_GRID_COLS, cols_w);
            cfg_write(REG_GRID_ROWS, rows_w);
        end
        cfg_write(REG_SPREAD_WEIGHT, pick_coef());
        cfg_write(REG_DECAY_FACTOR, pick_coef());

        area = rows_eff() * cols_eff();
        if (wide)
        begin
            cells  = 300;
            frames = 1;
        end
        else if (area > 60)
        begin
            cells  = $urandom_range(1, 60);
            frames = 1;
        end
        else
        begin
            cells  = area;
            frames = $urandom_range(1, 3);
        end

        for (int f = 0; f < frames; f++)
        begin
            for (int k = 0; k < cells; k++)
            begin
                // past the 257-beat lag: results flow, so a stall backs up
                if (wide && k == 260) holds_asked++;
                // stray padding inside the frame
                if (k > 0 && $urandom_range(15) == 0)
                    send_beat(CELL_W'($urandom), 1'b1, 1'b0, '0);
                send_beat(pick_cell(), 1'b0, 1'b0, '0);
            end
            if (cells < area)
            begin
                // partial frame: any padding is still inside it
                repeat ($urandom_range(2))
                    send_beat(CELL_W'($urandom), 1'b1, 1'b0, '0);
            end
            else
            begin
                how = $urandom_range(5);
                if (how < 2 && f + 1 < frames)
                begin
                    // next frame's cells flush this one
                end
                else
                begin
                    // coefficients changed with the frame still in the pipe
                    if (how == 2)
                    begin
                        drain();
                        cfg_write(REG_SPREAD_WEIGHT, pick_coef());
                        cfg_write(REG_DECAY_FACTOR, pick_coef());
                    end
                    // cols+1 beats flush; any beyond find nothing pending
                    repeat (cols_eff() + 1 + $urandom_range(2))
                        send_beat(CELL_W'($urandom), 1'b1, 1'b0, '0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        out_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Output check: every accepted cell against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        begin
            seen_cell.value = out_bus.new_value;
            seen_cell.row   = out_bus.out_row;
            seen_cell.col   = out_bus.out_col;
            seen_cell.last  = out_bus.frame_last;
            if (expected_cells.size() == 0)
            begin
                $display("%0t: unexpected cell: value %0d row %0d col %0d last %0b",
                         $time, seen_cell.value, seen_cell.row, seen_cell.col,
                         seen_cell.last);
                mismatches++;
            end
            else
            begin
                want_cell = expected_cells.pop_front();
                if (seen_cell !== want_cell)
                begin
                    $display("%0t: cell mismatch: expected value %0d row %0d col %0d last %0b",
                             $time, want_cell.value, want_cell.row, want_cell.col,
                             want_cell.last);
                    $display("%0t:                  actual value %0d row %0d col %0d last %0b",
                             $time, seen_cell.value, seen_cell.row, seen_cell.col,
                             seen_cell.last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: no beat on either side for too long means the block hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
                (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: watchdog: no beat for %0d cycles, %0d cells outstanding",
                         $time, quiet_cycles, expected_cells.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned beats_goal;
        bit          wide_done;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_GRID_ROWS;
        cfg_data          = '0;
        in_bus.valid      = 1'b0;
        in_bus.cell_value = '0;
        in_bus.is_padding = 1'b0;
        src_idle_pct      = 0;
        snk_idle_pct      = 0;
        holds_asked       = 0;
        holds_served      = 0;
        quiet_cycles      = 0;
        mismatches        = 0;
        beats_used        = 0;
        wide_done         = 1'b0;

        // predictor starts from the register reset values
        rows_cfg   = ROWS_RESET;
        cols_cfg   = COLS_RESET;
        weight_cfg = WEIGHT_RESET;
        decay_cfg  = DECAY_RESET;
        restart_stream();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Typed results: decay resets to zero so every cell is
        // zero; full-scale weight and decay on a 1x1 grid saturate both ways.
        directed_rows = '{
            // padding straight after reset: nothing pending
            beat_row(24'h5A5A5A, 1'b1),
            // 1x1 grid, with the size registers' unused upper bits set
            reg_row(REG_GRID_COLS, 16'hFE01),
            reg_row(REG_GRID_ROWS, 16'hF801),
            beat_row(CELL_MAX, 1'b0),
            beat_row(24'hFFFFFF, 1'b0),
            checked_row(24'd0),
            checked_row(24'd0),
            reg_row(REG_SPREAD_WEIGHT, 16'hFFFF),
            reg_row(REG_DECAY_FACTOR, 16'hFFFF),
            beat_row(CELL_MAX, 1'b0),
            beat_row(CELL_MIN, 1'b0),
            checked_row(CELL_MAX),
            checked_row(CELL_MIN),
            // smallest grid with edges, corners and an interior cell
            reg_row(REG_GRID_ROWS, 16'd3),
            reg_row(REG_GRID_COLS, 16'd3),
            reg_row(REG_SPREAD_WEIGHT, 16'h8000),
            reg_row(REG_DECAY_FACTOR, 16'hC000),
            beat_row(CELL_MAX, 1'b0),
            beat_row(CELL_MIN, 1'b0),
            beat_row(24'd1, 1'b0),
            beat_row(24'hFFFFFF, 1'b0),
            // padding inside the frame is dropped
            beat_row(24'hA5A5A5, 1'b1),
            beat_row(24'h000100, 1'b0),
            beat_row(CELL_MAX, 1'b0),
            beat_row(CELL_MIN, 1'b0),
            beat_row(24'h123456, 1'b0),
            beat_row(24'hEDCBAA, 1'b0),
            beat_row(24'h0F0F0F, 1'b1),
            beat_row(24'hF0F0F0, 1'b1),
            beat_row(24'h000000, 1'b1),
            beat_row(24'hFFFFFF, 1'b1)
        };
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                drain();
                cfg_write(directed_rows[i].reg_sel, directed_rows[i].wdata);
            end
            else
                send_beat(directed_rows[i].cell_data, directed_rows[i].pad,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // Random part in three stretches: slow receiver, slow sender, no gaps.
        // The wide grid with the receiver hold-off opens the last stretch.
        beats_goal = beats_used + RANDOM_BEATS;
        while (beats_used < beats_goal)
        begin
            if (beats_used < beats_goal - 2 * RANDOM_BEATS / 3)
            begin
                src_idle_pct = 22;
                snk_idle_pct = 85;
                run_phase(1'b0);
            end
            else if (beats_used < beats_goal - RANDOM_BEATS / 3)
            begin
                src_idle_pct = 85;
                snk_idle_pct = 22;
                run_phase(1'b0);
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
                run_phase(!wide_done);
                wide_done = 1'b1;
            end
        end

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### trail_map_diffuse_decay_core.f
rtl/tmdd_pkg.sv
rtl/tmdd_if.sv
rtl/tmdd_ram.sv
rtl/tmdd_ctrl.sv
rtl/tmdd_datapath.sv
rtl/trail_map_diffuse_decay_core.sv
rtl/tmdd_checker.sv
tb/sv/tb_top.sv
